FILE: design/utu_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// Used by every module of the block. Has no dependencies.
package utu_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  QMARK       = 8'h3F;
    localparam logic [5:0]  HIGH_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_TAG     = 6'b110111;
    localparam logic [20:0] SUPP_OFFSET = 21'h10000;
    localparam logic [1:0]  CONT_MARK   = 2'b10;
    localparam logic [2:0]  LEAD2_MARK  = 3'b110;
    localparam logic [3:0]  LEAD3_MARK  = 4'b1110;
    localparam logic [4:0]  LEAD4_MARK  = 5'b11110;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       string_done;
    } t_out;

    // One request's worth of output bytes; byte 0 goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            eos;
    } t_run;

endpackage

FILE: design/utu_front.sv
// Front end: accepts code units, holds a high surrogate and encodes each
// other request into a run of one to four bytes. Depends on utu_pkg.
module utu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  utu_pkg::t_in  i_in,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output utu_pkg::t_run o_run
);

    logic        r_pending;
    logic [9:0]  r_held;
    logic        n_pending;
    logic [9:0]  n_held;
    logic        accept;
    logic        is_high;
    logic        is_low;
    logic [20:0] cp;
    logic [1:0]  tail_n;
    logic [2:0]  total;
    logic [7:0]  tail0;
    logic [7:0]  tail1;
    logic [7:0]  tail2;
    logic [15:0] u;

    assign u       = i_in.code_unit;
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign is_high = (u[15:10] == utu_pkg::HIGH_TAG);
    assign is_low  = (u[15:10] == utu_pkg::LOW_TAG);
    assign cp      = {1'b0, r_held, u[9:0]} + utu_pkg::SUPP_OFFSET;

    always_comb begin
        tail0  = utu_pkg::QMARK;
        tail1  = 8'h00;
        tail2  = 8'h00;
        tail_n = 2'd1;
        priority if (is_high) begin
            tail_n = i_in.end_of_string ? 2'd1 : 2'd0;
        end else if (is_low) begin
            tail_n = 2'd1;
        end else if (u[15:7] == 9'd0) begin
            tail0 = u[7:0];
        end else if (u[15:11] == 5'd0) begin
            tail_n = 2'd2;
            tail0  = {utu_pkg::LEAD2_MARK, u[10:6]};
            tail1  = {utu_pkg::CONT_MARK, u[5:0]};
        end else begin
            tail_n = 2'd3;
            tail0  = {utu_pkg::LEAD3_MARK, u[15:12]};
            tail1  = {utu_pkg::CONT_MARK, u[11:6]};
            tail2  = {utu_pkg::CONT_MARK, u[5:0]};
        end
    end

    always_comb begin
        o_run.eos = i_in.end_of_string;
        total     = {2'b00, r_pending} + {1'b0, tail_n};
        if (r_pending && is_low) begin
            total       = 3'd4;
            o_run.bytes = {{utu_pkg::CONT_MARK, cp[5:0]},
                           {utu_pkg::CONT_MARK, cp[11:6]},
                           {utu_pkg::CONT_MARK, cp[17:12]},
                           {utu_pkg::LEAD4_MARK, cp[20:18]}};
        end else if (r_pending) begin
            o_run.bytes = {tail2, tail1, tail0, utu_pkg::QMARK};
        end else begin
            o_run.bytes = {8'h00, tail2, tail1, tail0};
        end
        o_run.last_idx = 2'(total - 3'd1);
        o_push         = accept && (total != 3'd0);
        n_pending      = is_high && !i_in.end_of_string;
        n_held         = n_pending ? u[9:0] : 10'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= 10'd0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

endmodule

FILE: design/utu_queue.sv
// Short queue of encoded byte runs between the front and back ends.
// Depends on utu_pkg.
module utu_queue #(
    parameter int DEPTH = utu_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utu_pkg::t_run i_push_run,
    output logic          o_full,
    output logic          o_head_valid,
    output utu_pkg::t_run o_head_run,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utu_pkg::t_run    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_run   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_run;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_head_valid |-> !i_pop)
        else $error("queue read while empty");
`endif

endmodule

FILE: design/utu_back.sv
// Back end: takes byte runs from the queue and sends them out one byte
// per cycle while not stalled, through a registered output. Depends on utu_pkg.
module utu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  utu_pkg::t_run i_head_run,
    output logic          o_pop,
    output logic          o_valid,
    output utu_pkg::t_out o_out,
    input  logic          i_stall
);

    utu_pkg::t_run r_run;
    utu_pkg::t_out r_out;
    logic          r_busy;
    logic [1:0]    r_idx;
    logic          r_out_valid;
    logic          load_ok;
    logic          at_end;

    assign load_ok = !r_out_valid || !i_stall;
    assign at_end  = (r_idx == r_run.last_idx);
    assign o_pop   = i_head_valid && (!r_busy || (load_ok && at_end));
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_ok) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (r_busy && load_ok) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_head_run;
        end
        if (load_ok && r_busy) begin
            r_out.out_byte    <= r_run.bytes[r_idx];
            r_out.last_of_run <= at_end;
            r_out.string_done <= at_end && r_run.eos;
        end
    end

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.string_done |-> r_out.last_of_run)
        else $error("end of string flagged on a byte that does not end its run");
`endif

endmodule

FILE: design/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder: a code unit is accepted every cycle while the queue has room.
// A request passes through the queue, the run register and the output register;
// its bytes then follow one per cycle while not stalled, one to four bytes per request.
// The single byte-wide output register sets that rate; the queue absorbs short bursts.
// Synchronous active-low reset empties the queue and output and clears the held surrogate.
// Depends on utu_pkg, utu_front, utu_queue and utu_back.
module utf16_to_utf8_transcoder_unit #(
    parameter int QUEUE_DEPTH = utu_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  utu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output utu_pkg::t_out o_out
);

    logic          full;
    logic          push;
    utu_pkg::t_run push_run;
    logic          head_valid;
    utu_pkg::t_run head_run;
    logic          pop;

    utu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_in    (i_in),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_run   (push_run)
    );

    utu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_run   (push_run),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head_run   (head_run),
        .i_pop        (pop)
    );

    utu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_run   (head_run),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .o_out        (o_out),
        .i_stall      (i_out_stall)
    );

endmodule
